// ===== src/ipv4ta_pkg.sv =====
// Shared types and codes for the IPv4 dotted-text address parser.
// No dependencies; imported by every module of the block.
package ipv4ta_pkg;

   localparam int unsigned AddrWidth = 32;
   localparam int unsigned ByteWidth = 8;
   localparam int unsigned NumEarlier = 3;

   // Item kinds on the request channel.
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Parse mode codes.
   localparam logic [2:0] MODE_START  = 3'd0;
   localparam logic [2:0] MODE_ZERO   = 3'd1;
   localparam logic [2:0] MODE_DIGITS = 3'd2;
   localparam logic [2:0] MODE_DONE   = 3'd3;
   localparam logic [2:0] MODE_FAILED = 3'd4;

   // Number base codes.
   localparam logic [1:0] BASE_DEC = 2'd0;
   localparam logic [1:0] BASE_OCT = 2'd1;
   localparam logic [1:0] BASE_HEX = 2'd2;

   localparam logic [AddrWidth-1:0] ALL_ONES = '1;

   typedef struct packed {
      logic                 kind;
      logic [ByteWidth-1:0] character;
   } req_type;

   typedef struct packed {
      logic [AddrWidth-1:0] address;
      logic                 failed;
   } rsp_type;

   // Control state of the parser that is reset and carried between words.
   typedef struct packed {
      logic [2:0]           mode;
      logic [AddrWidth-1:0] acc;
      logic [1:0]           base;
      logic [1:0]           count;
   } parse_state_type;

   // Bytes of the parts that came before the last one.
   typedef logic [NumEarlier-1:0][ByteWidth-1:0] parts_type;

endpackage

// ===== src/ipv4_text_to_address.sv =====
// IPv4 dotted-text parser: one character word in, one address word per end word.
// An end word is held in the input register and its address is loaded into the result
// register when the word retires, which raises rsp_valid.
// Throughput: one word per cycle; only an end word waits while an older result is unread.
// Synchronous active-high reset clears all control state; the parser also returns to
// its reset state after every end word. Depends on ipv4ta_pkg, ipv4ta_step, ipv4ta_pack.
module ipv4_text_to_address
   import ipv4ta_pkg::*;
#(
   parameter int unsigned MAX_CHARS = 28
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int unsigned CountWidth = $clog2(MAX_CHARS + 1);

   logic                  in_valid_ff, in_valid_in;
   req_type               req_ff;
   parse_state_type       state_ff, state_in;
   parts_type             parts_ff;
   logic [CountWidth-1:0] chars_ff, chars_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff;

   parse_state_type       step_nxt;
   logic                  part_wr;
   logic [ByteWidth-1:0]  part_data;
   rsp_type               pack_result;
   logic                  retire;
   logic                  char_live;

   ipv4ta_step u_step (
      .cur       (state_ff),
      .character (req_ff.character),
      .nxt       (step_nxt),
      .part_wr   (part_wr),
      .part_data (part_data)
   );

   ipv4ta_pack u_pack (
      .cur    (state_ff),
      .parts  (parts_ff),
      .result (pack_result)
   );

   always_comb begin
      // An end word may only retire into a free or draining result register.
      retire = in_valid_ff &&
               ((req_ff.kind == KIND_CHAR) || !rsp_valid_ff || rsp_ready);
      req_ready = !in_valid_ff || retire;
      in_valid_in = (req_valid && req_ready) || (in_valid_ff && !retire);

      char_live = (chars_ff < CountWidth'(MAX_CHARS)) &&
                  (state_ff.mode != MODE_DONE) && (state_ff.mode != MODE_FAILED);

      state_in     = state_ff;
      chars_in     = chars_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (retire) begin
         if (req_ff.kind == KIND_END) begin
            rsp_valid_in = 1'b1;
            state_in     = '{mode: MODE_START, acc: '0, base: BASE_DEC, count: 2'd0};
            chars_in     = '0;
         end else if (char_live) begin
            state_in = step_nxt;
            chars_in = chars_ff + CountWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= '{mode: MODE_START, acc: '0, base: BASE_DEC, count: 2'd0};
         chars_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         chars_ff     <= chars_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (retire && (req_ff.kind == KIND_CHAR) && char_live && part_wr) begin
         parts_ff[state_ff.count] <= part_data;
      end
      if (retire && (req_ff.kind == KIND_END)) begin
         rsp_ff <= pack_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== src/ipv4ta_step.sv =====
// Next-state logic for one text character of the address parser.
// Depends on ipv4ta_pkg.
module ipv4ta_step
   import ipv4ta_pkg::*;
(
   input  parse_state_type      cur,
   input  logic [ByteWidth-1:0] character,
   output parse_state_type      nxt,
   output logic                 part_wr,
   output logic [ByteWidth-1:0] part_data
);

   logic [AddrWidth-1:0] eff_acc;
   logic [1:0]           eff_base;
   logic                 is_digit;
   logic                 is_lower_hex;
   logic                 is_upper_hex;
   logic                 is_space;
   logic [3:0]           digit_val;
   logic [AddrWidth-1:0] scaled;

   always_comb begin
      // Entering a part starts from zero; after a leading zero the part is octal.
      eff_acc  = (cur.mode == MODE_START) ? '0 : cur.acc;
      eff_base = (cur.mode == MODE_START) ? BASE_DEC :
                 (cur.mode == MODE_ZERO)  ? BASE_OCT : cur.base;

      is_digit     = (character >= 8'h30) && (character <= 8'h39);
      is_lower_hex = (character >= 8'h61) && (character <= 8'h66);
      is_upper_hex = (character >= 8'h41) && (character <= 8'h46);
      is_space     = (character == 8'h20) || ((character >= 8'h09) && (character <= 8'h0d));

      // Letters a-f and A-F have low nibbles 1..6, so the value is nibble plus nine.
      digit_val = is_digit ? character[3:0] : 4'(character[3:0] + 4'd9);

      case (eff_base)
         BASE_HEX: scaled = {eff_acc[AddrWidth-5:0], 4'b0000};
         BASE_OCT: scaled = {eff_acc[AddrWidth-4:0], 3'b000};
         default:  scaled = {eff_acc[AddrWidth-4:0], 3'b000} + {eff_acc[AddrWidth-2:0], 1'b0};
      endcase

      nxt       = cur;
      nxt.acc   = eff_acc;
      nxt.base  = eff_base;
      part_wr   = 1'b0;
      part_data = eff_acc[ByteWidth-1:0];

      if (character == 8'h00) begin
         nxt.mode = MODE_DONE;
      end else if ((cur.mode == MODE_START) && (character == 8'h30)) begin
         nxt.base = BASE_OCT;
         nxt.mode = MODE_ZERO;
      end else if ((cur.mode == MODE_ZERO) && ((character == 8'h78) || (character == 8'h58))) begin
         nxt.base = BASE_HEX;
         nxt.mode = MODE_DIGITS;
      end else if (is_digit || ((eff_base == BASE_HEX) && (is_lower_hex || is_upper_hex))) begin
         nxt.acc  = scaled + AddrWidth'(digit_val);
         nxt.mode = MODE_DIGITS;
      end else if (character == 8'h2e) begin
         if ((cur.count == 2'd3) || (eff_acc > AddrWidth'(8'hff))) begin
            nxt.mode = MODE_FAILED;
         end else begin
            part_wr   = 1'b1;
            nxt.count = cur.count + 2'd1;
            nxt.acc   = '0;
            nxt.base  = BASE_DEC;
            nxt.mode  = MODE_START;
         end
      end else if (is_space) begin
         nxt.mode = MODE_DONE;
      end else begin
         nxt.mode = MODE_FAILED;
      end
   end

endmodule

// ===== src/ipv4ta_pack.sv =====
// Final range check and packing of the parts into a 32-bit address.
// Depends on ipv4ta_pkg.
module ipv4ta_pack
   import ipv4ta_pkg::*;
(
   input  parse_state_type cur,
   input  parts_type       parts,
   output rsp_type         result
);

   logic                 bad;
   logic [AddrWidth-1:0] addr;

   always_comb begin
      bad  = (cur.mode == MODE_FAILED);
      addr = cur.acc;
      case (cur.count)
         2'd1: begin
            bad  = bad || (cur.acc > 32'h00ff_ffff);
            addr = {parts[0], cur.acc[23:0]};
         end
         2'd2: begin
            bad  = bad || (cur.acc > 32'h0000_ffff);
            addr = {parts[0], parts[1], cur.acc[15:0]};
         end
         2'd3: begin
            bad  = bad || (cur.acc > 32'h0000_00ff);
            addr = {parts[0], parts[1], parts[2], cur.acc[7:0]};
         end
         default: begin
            addr = cur.acc;
         end
      endcase
      result.address = bad ? ALL_ONES : addr;
      result.failed  = bad;
   end

endmodule

// ===== src/ipv4ta_checker.sv =====
// Port-level checks for the IPv4 text parser, bound to the top level.
// Depends on ipv4ta_pkg and ipv4_text_to_address.
module ipv4ta_checker
   import ipv4ta_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A result that is not taken stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // A failure always reports the all-ones address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.failed |-> rsp_data.address == ALL_ONES)
      else $error("failed result without all-ones address");

   // The input side never stalls while the result side is empty.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with no pending result");

   // A waiting input word is held steady by the sender.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("waiting input word changed or dropped");

   // Nothing is shown right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind ipv4_text_to_address ipv4ta_checker u_ipv4ta_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the IPv4 dotted-text address parser: character words
// in, address words out, checked against a parser model kept inside the testbench.
// Depends on ipv4ta_pkg and ipv4_text_to_address.
module tb;
   import ipv4ta_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TextLimit = 28;
   localparam int unsigned HoldOffCycles = 300;

   typedef logic [ByteWidth-1:0] text_type[$];

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   ipv4_text_to_address #(
      .MAX_CHARS(TextLimit)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   req_type     pending_words[$];
   rsp_type     expected_addresses[$];
   int unsigned send_idle_pct = 31;
   int unsigned recv_idle_pct = 31;
   int unsigned hold_off_requests = 0;
   int unsigned hold_off_served = 0;
   int unsigned hold_left = 0;
   int unsigned words_queued = 0;
   int unsigned texts_queued = 0;
   int unsigned words_sent = 0;
   int unsigned addresses_checked = 0;
   int unsigned malformed_seen = 0;
   int unsigned failures = 0;

   // Parser state as the testbench expects it to be.
   logic [2:0]           p_mode;
   logic [AddrWidth-1:0] p_acc;
   logic [1:0]           p_base;
   logic [ByteWidth-1:0] p_parts[NumEarlier];
   logic [1:0]           p_count;
   int unsigned          p_taken;

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   task automatic clear_parser();
      p_mode = MODE_START;
      p_acc = '0;
      p_base = BASE_DEC;
      foreach (p_parts[i]) p_parts[i] = '0;
      p_count = '0;
      p_taken = 0;
   endtask

   function automatic logic is_blank(logic [ByteWidth-1:0] c);
      return c == " " || (c >= 8'h09 && c <= 8'h0d);
   endfunction

   // A character inside the digits of a part: a digit, a dot, whitespace or a stray.
   task automatic take_in_part(logic [ByteWidth-1:0] c);
      logic [AddrWidth-1:0] radix;
      radix = (p_base == BASE_HEX) ? 16 : (p_base == BASE_OCT) ? 8 : 10;
      if (c >= "0" && c <= "9") begin
         p_acc = p_acc * radix + (c - "0");
         p_mode = MODE_DIGITS;
      end else if (p_base == BASE_HEX && c >= "a" && c <= "f") begin
         p_acc = (p_acc << 4) + (c - "a" + 10);
         p_mode = MODE_DIGITS;
      end else if (p_base == BASE_HEX && c >= "A" && c <= "F") begin
         p_acc = (p_acc << 4) + (c - "A" + 10);
         p_mode = MODE_DIGITS;
      end else if (c == ".") begin
         if (p_count >= NumEarlier || p_acc > 32'hff) begin
            p_mode = MODE_FAILED;
         end else begin
            p_parts[p_count] = p_acc[ByteWidth-1:0];
            p_count = p_count + 2'd1;
            p_acc = '0;
            p_base = BASE_DEC;
            p_mode = MODE_START;
         end
      end else if (is_blank(c)) begin
         p_mode = MODE_DONE;
      end else begin
         p_mode = MODE_FAILED;
      end
   endtask

   task automatic parse_word(req_type w);
      logic [AddrWidth-1:0] addr;
      logic                 bad;
      if (w.kind == KIND_CHAR) begin
         if (p_taken >= TextLimit || p_mode == MODE_DONE || p_mode == MODE_FAILED) return;
         p_taken++;
         if (w.character == 8'h00) begin
            p_mode = MODE_DONE;
         end else if (p_mode == MODE_START) begin
            p_acc = '0;
            if (w.character == "0") begin
               p_base = BASE_OCT;
               p_mode = MODE_ZERO;
            end else begin
               p_base = BASE_DEC;
               take_in_part(w.character);
            end
         end else if (p_mode == MODE_ZERO) begin
            if (w.character == "x" || w.character == "X") begin
               p_base = BASE_HEX;
               p_mode = MODE_DIGITS;
            end else begin
               p_base = BASE_OCT;
               take_in_part(w.character);
            end
         end else begin
            take_in_part(w.character);
         end
         return;
      end
      addr = p_acc;
      bad = (p_mode == MODE_FAILED);
      if (!bad) begin
         case (p_count)
            2'd1: begin
               if (addr > 32'hffffff) bad = 1'b1;
               else addr = addr | {p_parts[0], 24'd0};
            end
            2'd2: begin
               if (addr > 32'hffff) bad = 1'b1;
               else addr = addr | {p_parts[0], p_parts[1], 16'd0};
            end
            2'd3: begin
               if (addr > 32'hff) bad = 1'b1;
               else addr = addr | {p_parts[0], p_parts[1], p_parts[2], 8'd0};
            end
            default: ;
         endcase
      end
      expected_addresses.push_back('{address: bad ? ALL_ONES : addr, failed: bad});
      clear_parser();
   endtask

   // Driver: presents the next pending word once the current one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         clear_parser();
      end else begin
         if (req_valid && req_ready) begin
            parse_word(req_data);
            words_sent++;
         end
         if (!req_valid || req_ready) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_words.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each address word and drives ready, including the long hold-off.
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            addresses_checked++;
            if (rsp_data.failed) malformed_seen++;
            if (expected_addresses.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("ERROR: unexpected address word %h failed=%b",
                           rsp_data.address, rsp_data.failed);
            end else begin
               want = expected_addresses.pop_front();
               if (rsp_data.address !== want.address || rsp_data.failed !== want.failed) begin
                  failures++;
                  if (failures <= 10)
                     $display("ERROR: address exp %h got %h, failed exp %b got %b",
                              want.address, rsp_data.address, want.failed, rsp_data.failed);
               end
            end
         end
         if (hold_left == 0 && hold_off_served < hold_off_requests) begin
            hold_left = HoldOffCycles;
            hold_off_served++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   task automatic queue_text(text_type text);
      foreach (text[i]) pending_words.push_back('{kind: KIND_CHAR, character: text[i]});
      pending_words.push_back('{kind: KIND_END, character: ByteWidth'($urandom_range(0, 255))});
      words_queued += text.size() + 1;
      texts_queued++;
   endtask

   task automatic queue_string(string s);
      text_type text;
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
      queue_text(text);
   endtask

   function automatic logic [AddrWidth-1:0] pick_value(logic [AddrWidth-1:0] limit);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return limit;
         2: return limit + 1;
         3: return $urandom();
         default: return $urandom_range(0, limit);
      endcase
   endfunction

   // Writes a part in decimal, octal or hex, sometimes with leading zeros.
   task automatic put_number(ref text_type text, input logic [AddrWidth-1:0] value);
      text_type             digits;
      int unsigned          radix;
      int unsigned          pad;
      logic [AddrWidth-1:0] v;
      logic [ByteWidth-1:0] d;
      case ($urandom_range(0, 3))
         0, 1: radix = 10;
         2: radix = 8;
         default: radix = 16;
      endcase
      v = value;
      do begin
         d = ByteWidth'(v % radix);
         if (d < 10) digits.push_front("0" + d);
         else digits.push_front(($urandom_range(0, 1) ? "a" : "A") + d - 8'd10);
         v = v / radix;
      end while (v != 0);
      pad = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : 0;
      if (radix == 8) text.push_back("0");
      if (radix == 16) begin
         text.push_back("0");
         text.push_back($urandom_range(0, 1) ? "x" : "X");
      end
      if (radix != 10) repeat (pad) text.push_back("0");
      foreach (digits[i]) text.push_back(digits[i]);
   endtask

   task automatic make_address_text(ref text_type text);
      int unsigned          parts;
      logic [AddrWidth-1:0] limit;
      parts = $urandom_range(1, 4);
      for (int i = 0; i < parts; i++) begin
         if (i < parts - 1) limit = 32'hff;
         else limit = (parts == 1) ? 32'hffffffff : (parts == 2) ? 32'hffffff :
                      (parts == 3) ? 32'hffff : 32'hff;
         put_number(text, pick_value(limit));
         if (i < parts - 1) text.push_back(".");
      end
      case ($urandom_range(0, 9))
         0: begin
            text.push_back($urandom_range(0, 1) ? 8'h20 :
                           ByteWidth'($urandom_range(8'h09, 8'h0d)));
            repeat ($urandom_range(0, 3)) text.push_back(ByteWidth'($urandom_range(0, 255)));
         end
         1: begin
            text.push_back(8'h00);
            repeat ($urandom_range(0, 3)) text.push_back(ByteWidth'($urandom_range(0, 255)));
         end
         2: text.push_back(ByteWidth'($urandom_range(0, 255)));
         default: ;
      endcase
   endtask

   // Mostly well-formed addresses, some damaged ones and some plain noise.
   task automatic queue_random_texts(int unsigned words);
      text_type    text;
      int unsigned goal;
      int unsigned pick;
      int unsigned pos;
      string       alphabet;
      alphabet = "0123456789abcdefABCDEFxX... \t";
      goal = words_queued + words;
      while (words_queued < goal) begin
         text = {};
         pick = $urandom_range(0, 99);
         if (pick < 90) make_address_text(text);
         if (pick >= 75 && pick < 90) begin
            pos = $urandom_range(0, text.size() - 1);
            case ($urandom_range(0, 2))
               0: text[pos] = ByteWidth'($urandom_range(0, 255));
               1: text.insert(pos, ".");
               default: text.delete(pos);
            endcase
         end else if (pick >= 90) begin
            repeat ($urandom_range(0, 35)) begin
               if ($urandom_range(0, 1)) text.push_back(alphabet[$urandom_range(0, 28)]);
               else text.push_back(ByteWidth'($urandom_range(0, 255)));
            end
         end
         queue_text(text);
      end
   endtask

   task automatic wait_until_drained();
      while (pending_words.size() != 0 || req_valid || expected_addresses.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      text_type text;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_string("");
      queue_string(".");
      queue_string("255.255.255.255");
      queue_string("0xFFffFFff");
      queue_string("4294967296");
      queue_string("0377.0x7F.08.9");
      queue_string("1.2.3.4.5");
      queue_string("256.1");
      queue_string("1.16777216");
      queue_string("1.2.65536");
      queue_string("1.2.3.256");
      queue_string("1.2 junk");
      queue_string("\t");
      queue_string("0x");
      queue_string("1a");
      text = {"1", ".", "2", 8'h00, "9"};
      queue_text(text);
      text = {"1", 8'h80};
      queue_text(text);
      // Only the first 28 characters count, so the trailing part is dropped.
      text = {};
      repeat (27) text.push_back("0");
      text = {text, "1", ".", "2"};
      queue_text(text);

      queue_random_texts(450);
      wait_until_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random_texts(350);
      wait_until_drained();

      // Receiver stalls for a long stretch while the sender keeps the input busy.
      hold_off_requests++;
      queue_random_texts(150);
      wait_until_drained();

      send_idle_pct = 31;
      recv_idle_pct = 31;
      queue_random_texts(400);

      wait_until_drained();
      repeat (20) @(negedge clock);

      $display("Sent %0d texts as %0d words; %0d addresses checked, %0d reported malformed.",
               texts_queued, words_sent, addresses_checked, malformed_seen);
      $display("Covered corner texts, damaged and noisy input, a %0d-cycle output stall %s",
               HoldOffCycles, "and a drain.");
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== ipv4_text_to_address.f =====
src/ipv4ta_pkg.sv
src/ipv4ta_step.sv
src/ipv4ta_pack.sv
src/ipv4_text_to_address.sv
src/ipv4ta_checker.sv
tb/sv/tb.sv
